FILE: hdl/multiplexed_seven_segment_scanner_top_assert.svh
// Assertion macros shared by the scanner modules.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_TOP_ASSERT_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MSS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mss_pkg.sv
// Shared types, constants and functions of the seven-segment scanner.
package mss_pkg;

    localparam int unsigned REFRESH_MS  = 10;
    localparam int unsigned MAX_DIGITS  = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned TIME_W = 16;
    localparam int unsigned IN_W   = 16;
    localparam int unsigned VAL_W  = 14;
    localparam int unsigned CNT_W  = 3;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned SEG_W  = 8;
    localparam int unsigned EN_W   = 4;
    localparam int unsigned THR_W  = 8;
    localparam int unsigned DIG_W  = 4;
    localparam int unsigned PROD_W = 2 * VAL_W;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMON_CATHODE = 1'b1;

    localparam logic [CNT_W-1:0] DIGIT_COUNT_RESET = 3'd4;

    localparam logic [VAL_W-1:0] VALUE_MAX = 14'd9999;

    // Reciprocals of 10, 100 and 1000 with their shifts; exact for values up to 9999.
    localparam logic [VAL_W-1:0] RECIP_10   = 14'd13108;
    localparam int unsigned      SHIFT_10   = 17;
    localparam logic [VAL_W-1:0] RECIP_100  = 14'd10486;
    localparam int unsigned      SHIFT_100  = 20;
    localparam logic [VAL_W-1:0] RECIP_1000 = 14'd8389;
    localparam int unsigned      SHIFT_1000 = 23;

    // One queued word: the scan decision and the quotient holding the wanted digit.
    typedef struct packed {
        logic             updated;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] quot;
    } entry_t;

    function automatic logic [THR_W-1:0] refresh_threshold(input logic [CNT_W-1:0] count);
        logic [THR_W-1:0] thr;
        case (count)
            3'd1: begin
                thr = THR_W'(REFRESH_MS / 1);
            end
            3'd2: begin
                thr = THR_W'(REFRESH_MS / 2);
            end
            3'd3: begin
                thr = THR_W'(REFRESH_MS / 3);
            end
            3'd4: begin
                thr = THR_W'(REFRESH_MS / 4);
            end
            default: begin
                thr = THR_W'(REFRESH_MS);
            end
        endcase
        return thr;
    endfunction

    // Segment patterns, bit0 is segment a, point never lit.
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIG_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0: begin
                pat = 8'h3F;
            end
            4'd1: begin
                pat = 8'h06;
            end
            4'd2: begin
                pat = 8'h5B;
            end
            4'd3: begin
                pat = 8'h4F;
            end
            4'd4: begin
                pat = 8'h66;
            end
            4'd5: begin
                pat = 8'h6D;
            end
            4'd6: begin
                pat = 8'h7D;
            end
            4'd7: begin
                pat = 8'h07;
            end
            4'd8: begin
                pat = 8'h7F;
            end
            4'd9: begin
                pat = 8'h6F;
            end
            default: begin
                pat = 8'h00;
            end
        endcase
        return pat;
    endfunction

endpackage

FILE: hdl/mss_front.sv
// Front end: timing decision, scan index and digit quotient for each word.
`include "multiplexed_seven_segment_scanner_top_assert.svh"

module mss_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mss_pkg::CNT_W-1:0]     digit_count,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mss_pkg::TIME_W-1:0]    s_now_ms,
    input  logic [mss_pkg::IN_W-1:0]      s_shown_value,
    output logic                          q_valid,
    input  logic                          q_ready,
    output mss_pkg::entry_t               q_entry
);

    logic [mss_pkg::TIME_W-1:0] last_time_reg, last_time_next;
    logic [mss_pkg::IDX_W-1:0]  scan_index_reg, scan_index_next;

    logic [mss_pkg::CNT_W-1:0]  count;
    logic [mss_pkg::THR_W-1:0]  threshold;
    logic [mss_pkg::TIME_W-1:0] elapsed;
    logic                       do_update;
    logic [mss_pkg::IDX_W-1:0]  idx;
    logic [mss_pkg::CNT_W-1:0]  idx_inc;
    logic [mss_pkg::VAL_W-1:0]  sat_value;
    logic [mss_pkg::PROD_W-1:0] prod_10, prod_100, prod_1000;
    logic                       accept;

    always_comb begin
        if (digit_count == '0) begin
            count = mss_pkg::CNT_W'(1);
        end else if (digit_count > mss_pkg::CNT_W'(mss_pkg::MAX_DIGITS)) begin
            count = mss_pkg::CNT_W'(mss_pkg::MAX_DIGITS);
        end else begin
            count = digit_count;
        end
    end

    assign threshold = mss_pkg::refresh_threshold(count);
    assign elapsed   = s_now_ms - last_time_reg;
    assign do_update = elapsed > mss_pkg::TIME_W'(threshold);

    // An index left beyond a lowered count restarts at the ones digit.
    assign idx     = (mss_pkg::CNT_W'(scan_index_reg) >= count) ? '0 : scan_index_reg;
    assign idx_inc = mss_pkg::CNT_W'(idx) + mss_pkg::CNT_W'(1);

    assign sat_value = (s_shown_value > mss_pkg::IN_W'(mss_pkg::VALUE_MAX))
                     ? mss_pkg::VALUE_MAX : s_shown_value[mss_pkg::VAL_W-1:0];

    assign prod_10   = mss_pkg::PROD_W'(sat_value) * mss_pkg::PROD_W'(mss_pkg::RECIP_10);
    assign prod_100  = mss_pkg::PROD_W'(sat_value) * mss_pkg::PROD_W'(mss_pkg::RECIP_100);
    assign prod_1000 = mss_pkg::PROD_W'(sat_value) * mss_pkg::PROD_W'(mss_pkg::RECIP_1000);

    always_comb begin
        q_entry.updated = do_update;
        q_entry.idx     = idx;
        case (idx)
            2'd0: begin
                q_entry.quot = sat_value;
            end
            2'd1: begin
                q_entry.quot = mss_pkg::VAL_W'(prod_10 >> mss_pkg::SHIFT_10);
            end
            2'd2: begin
                q_entry.quot = mss_pkg::VAL_W'(prod_100 >> mss_pkg::SHIFT_100);
            end
            default: begin
                q_entry.quot = mss_pkg::VAL_W'(prod_1000 >> mss_pkg::SHIFT_1000);
            end
        endcase
    end

    assign q_valid = s_valid;
    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    always_comb begin
        last_time_next  = last_time_reg;
        scan_index_next = scan_index_reg;
        if (accept && do_update) begin
            last_time_next  = s_now_ms;
            scan_index_next = (idx_inc >= count) ? '0 : idx_inc[mss_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg  <= '0;
            scan_index_reg <= '0;
        end else begin
            last_time_reg  <= last_time_next;
            scan_index_reg <= scan_index_next;
        end
    end

    `MSS_ASSERT_NEXT(a_time_follows_update, aclk, aresetn, accept && do_update, last_time_reg == $past(s_now_ms), "last update time not taken from the updating word")

endmodule

FILE: hdl/mss_queue.sv
// Short queue that decouples the front end from the display back end.
`include "multiplexed_seven_segment_scanner_top_assert.svh"

module mss_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mss_pkg::entry_t in_entry,
    output logic            out_valid,
    input  logic            out_ready,
    output mss_pkg::entry_t out_entry
);

    localparam int unsigned PTR_W = (mss_pkg::QUEUE_DEPTH > 1) ? $clog2(mss_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(mss_pkg::QUEUE_DEPTH + 1);

    mss_pkg::entry_t    slot_reg [mss_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               push, pop;

    assign in_ready  = fill_reg != FILL_W'(mss_pkg::QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mss_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mss_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

    `MSS_ASSERT_NOW(a_fill_bounded, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(mss_pkg::QUEUE_DEPTH), "queue fill beyond its depth")

endmodule

FILE: hdl/mss_back.sv
// Back end: digit extraction, segment lookup, drive latches and result register.
`include "multiplexed_seven_segment_scanner_top_assert.svh"

module mss_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        common_cathode,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  mss_pkg::entry_t             q_entry,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mss_pkg::SEG_W-1:0]   m_segments,
    output logic [mss_pkg::EN_W-1:0]    m_digit_enable,
    output logic                        m_updated
);

    logic [mss_pkg::SEG_W-1:0] seg_latch_reg, seg_latch_next;
    logic [mss_pkg::EN_W-1:0]  en_latch_reg, en_latch_next;
    logic                      out_valid_reg, out_valid_next;
    logic [mss_pkg::SEG_W-1:0] out_seg_reg;
    logic [mss_pkg::EN_W-1:0]  out_en_reg;
    logic                      out_upd_reg;

    logic [mss_pkg::PROD_W-1:0] prod;
    logic [mss_pkg::VAL_W-1:0]  tens;
    logic [mss_pkg::VAL_W-1:0]  rem;
    logic [mss_pkg::DIG_W-1:0]  digit;
    logic [mss_pkg::SEG_W-1:0]  pattern;
    logic                       pop;

    // Remainder by ten of the queued quotient gives the wanted decimal digit.
    assign prod    = mss_pkg::PROD_W'(q_entry.quot) * mss_pkg::PROD_W'(mss_pkg::RECIP_10);
    assign tens    = mss_pkg::VAL_W'(prod >> mss_pkg::SHIFT_10);
    assign rem     = q_entry.quot - mss_pkg::VAL_W'(tens * mss_pkg::VAL_W'(10));
    assign digit   = rem[mss_pkg::DIG_W-1:0];
    assign pattern = common_cathode ? mss_pkg::seg_pattern(digit)
                                    : ~mss_pkg::seg_pattern(digit);

    assign q_ready = !out_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        seg_latch_next = seg_latch_reg;
        en_latch_next  = en_latch_reg;
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
            if (q_entry.updated) begin
                seg_latch_next = pattern;
                en_latch_next  = mss_pkg::EN_W'(1) << q_entry.idx;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_latch_reg <= '0;
            en_latch_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            seg_latch_reg <= seg_latch_next;
            en_latch_reg  <= en_latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_seg_reg <= seg_latch_next;
            out_en_reg  <= en_latch_next;
            out_upd_reg <= q_entry.updated;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_segments     = out_seg_reg;
    assign m_digit_enable = out_en_reg;
    assign m_updated      = out_upd_reg;

    `MSS_ASSERT_NOW(a_enable_onehot0, aclk, aresetn, 1'b1, $onehot0(en_latch_reg), "more than one digit enabled")
    `MSS_ASSERT_NOW(a_update_lights_digit, aclk, aresetn, out_valid_reg && out_upd_reg, $onehot(out_en_reg), "scan step without exactly one digit lit")

endmodule

FILE: hdl/multiplexed_seven_segment_scanner_top.sv
// Multiplexed seven-segment scanner: takes time sample and value words and returns one drive
// word for each, via the queue and the back end's result register. The front end decides
// from the wrapping millisecond difference whether a scan step is due and computes the
// digit quotient; a two-word queue separates it from the back end, which extracts the digit,
// looks up its segment pattern, applies polarity and holds the drive latches. Throughput
// is set by the scan-state update in the front end: one word per cycle while the result
// side keeps taking words. Configuration writes complete in the cycle they are presented.
module multiplexed_seven_segment_scanner_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mss_pkg::TIME_W-1:0]        s_now_ms,
    input  logic [mss_pkg::IN_W-1:0]          s_shown_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mss_pkg::SEG_W-1:0]         m_segments,
    output logic [mss_pkg::EN_W-1:0]          m_digit_enable,
    output logic                              m_updated
);

    logic [mss_pkg::CNT_W-1:0] digit_count_reg, digit_count_next;
    logic                      common_cathode_reg, common_cathode_next;

    logic            fq_valid, fq_ready;
    mss_pkg::entry_t fq_entry;
    logic            qb_valid, qb_ready;
    mss_pkg::entry_t qb_entry;

    assign cfg_ready = 1'b1;

    always_comb begin
        digit_count_next    = digit_count_reg;
        common_cathode_next = common_cathode_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mss_pkg::CFG_DIGIT_COUNT: begin
                    digit_count_next = cfg_data;
                end
                mss_pkg::CFG_COMMON_CATHODE: begin
                    common_cathode_next = cfg_data[0];
                end
                default: begin
                    digit_count_next = digit_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg    <= mss_pkg::DIGIT_COUNT_RESET;
            common_cathode_reg <= 1'b1;
        end else begin
            digit_count_reg    <= digit_count_next;
            common_cathode_reg <= common_cathode_next;
        end
    end

    mss_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .digit_count   (digit_count_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_now_ms      (s_now_ms),
        .s_shown_value (s_shown_value),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_entry       (fq_entry)
    );

    mss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_entry (qb_entry)
    );

    mss_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .common_cathode (common_cathode_reg),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_entry        (qb_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_segments     (m_segments),
        .m_digit_enable (m_digit_enable),
        .m_updated      (m_updated)
    );

endmodule
